// File: design/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII core
// Field widths, the control word of a BCD cell and the sequencer states.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W = 32;          // width of the value field on the input
   localparam int CHAR_W  = 6;           // width of the digit_char field
   localparam int DIGIT_W = 4;           // one BCD digit

   // '0' is 6'h30 after masking to six bits, so a digit sits under 2'b11
   localparam logic [CHAR_W-DIGIT_W-1:0] ASCII_ZERO_HI = 2'b11;

   localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;       // zero the digit
      logic bit_shift;   // add-3 correct, then shift one binary bit in
      logic dig_shift;   // take the lower neighbor's digit
   } cell_ctrl_type;

endpackage

// File: design/b2da_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_if: valid/ready channels of the binary to decimal ASCII core
// Request carries the binary value, response carries one ASCII digit a beat.
// ----------------------------------------------------------------------------
interface b2da_req_if;
   logic                           valid;
   logic                           ready;
   logic [b2da_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [b2da_pkg::CHAR_W-1:0]    digit_char;
   logic                           last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: design/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core: unsigned binary to decimal ASCII digits
// Double-dabble over a chain of BCD cells, then a digit-by-digit readout,
// most significant first, leading zeros dropped, last digit flagged.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents                 per item
//   -------   ---   ---------------------------   ------------------
//   req_ch    in    value[31:0]                   one beat
//   rsp_ch    out   digit_char[5:0], last_digit   1 to NUM_DIGITS beats
//
// One bit per cycle goes through the cell chain, then one digit per cycle
// comes off the top cell, skipped leading zeros included; a real digit is
// held while the response stalls. NUM_DIGITS is 10 at 32 bits.
// Reset clears the sequencer and the output valid; cells need no reset.
// A stalled response holds the readout; the next request is taken as soon as
// the last digit sits in the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   b2da_req_if.sink     req_ch,
   b2da_rsp_if.source   rsp_ch
);
   import b2da_pkg::*;

   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
   localparam int POS_W      = $clog2(NUM_DIGITS);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    seen_ff, seen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]      char_ff, char_in;
   logic                    last_ff, last_in;

   cell_ctrl_type           ctrl;
   logic                    load_out;
   logic                    accept;
   logic                    emit_slot;
   logic                    pos_last;
   logic                    bit_last;
   logic                    show;
   logic [DIGIT_W-1:0]      top_digit;

   logic [DIGIT_W-1:0]      digit [NUM_DIGITS];
   logic                    carry [NUM_DIGITS-1];

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic                bit_src;
      logic [DIGIT_W-1:0]  dig_src;
      if (i == 0) begin : g_low
         assign bit_src = bin_ff[VALUE_BITS-1];
         assign dig_src = '0;
      end else begin : g_up
         assign bit_src = carry[i-1];
         assign dig_src = digit[i-1];
      end
      if (i == NUM_DIGITS - 1) begin : g_top
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .bit_in    (bit_src),
            .digit_lo  (dig_src),
            .digit     (digit[i]),
            .carry_out ()
         );
      end else begin : g_mid
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .bit_in    (bit_src),
            .digit_lo  (dig_src),
            .digit     (digit[i]),
            .carry_out (carry[i])
         );
      end
   end

   assign top_digit = digit[NUM_DIGITS-1];

   // ---------------- sequencer ----------------
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign emit_slot    = !rsp_valid_ff || rsp_ch.ready;
   assign pos_last     = (pos_ff == POS_W'(NUM_DIGITS - 1));
   assign bit_last     = (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1));
   assign show         = seen_ff || (top_digit != '0) || pos_last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bit_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pos_last && emit_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl       = '0;
      load_out   = 1'b0;
      bin_in     = bin_ff;
      bit_cnt_in = bit_cnt_ff;
      pos_in     = pos_ff;
      seen_in    = seen_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.clear = 1'b1;
               bin_in     = VALUE_BITS'(req_ch.value);
               bit_cnt_in = '0;
            end
         end
         ST_CONVERT: begin
            ctrl.bit_shift = 1'b1;
            bin_in         = {bin_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in     = bit_cnt_ff + 1'b1;
            pos_in         = '0;
            seen_in        = 1'b0;
         end
         ST_EMIT: begin
            // drop leading zeros at once; hold a real digit until the slot frees
            if (!show || emit_slot) begin
               ctrl.dig_shift = 1'b1;
               pos_in         = pos_ff + 1'b1;
            end
            if (show && emit_slot) begin
               load_out = 1'b1;
               seen_in  = 1'b1;
               char_in  = top_digit;
               last_in  = pos_last;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bit_cnt_ff <= bit_cnt_in;
      pos_ff     <= pos_in;
      seen_ff    <= seen_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.digit_char = {ASCII_ZERO_HI, char_ff};
   assign rsp_ch.last_digit = last_ff;

   // ---------------- checks ----------------
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff <= DIGIT_MAX))
      else $error("emitted digit out of range");

   a_top_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (top_digit <= DIGIT_MAX))
      else $error("top cell holds a non-BCD digit");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=> (rsp_valid_ff && last_ff))
      else $error("readout ended without a flagged last digit");

   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (load_out && !seen_ff && !pos_last) |-> (top_digit != '0))
      else $error("leading zero emitted");

endmodule

// File: design/b2da_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_cell: one BCD digit of the double-dabble chain
// Holds a decimal digit; shifts binary bits up the chain during conversion
// and passes whole digits up the chain while the result is read out.
// ----------------------------------------------------------------------------
module b2da_cell (
   input  logic                              clock,
   input  b2da_pkg::cell_ctrl_type           ctrl,
   input  logic                              bit_in,
   input  logic [b2da_pkg::DIGIT_W-1:0]      digit_lo,
   output logic [b2da_pkg::DIGIT_W-1:0]      digit,
   output logic                              carry_out
);
   import b2da_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adjusted;

   assign adjusted  = (digit_ff >= ADJ_LIMIT) ? (digit_ff + ADJ_ADD) : digit_ff;
   assign carry_out = adjusted[DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.bit_shift) begin
         digit_in = {adjusted[DIGIT_W-2:0], bit_in};
      end else if (ctrl.dig_shift) begin
         digit_in = digit_lo;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule
